// ===== rtl/qmsd_pkg.sv =====
// shared constants, types and codes of the quantized mesh stream decoder
package qmsd_pkg;

   localparam int QUANT_MAX_DEF  = 32767;
   localparam int COORD_BITS_DEF = 48;

   localparam int AXES       = 3;
   localparam int CODE_W     = 16;
   localparam int IDX_W      = 32;
   localparam int ACC_W      = 32;
   localparam int MIN_W      = 48;
   localparam int SPAN_W     = 47;
   localparam int SPAN_RST   = 65536;

   localparam int REQ_DATA_W = 3 * CODE_W + IDX_W;
   localparam int REQ_USER_W = 2;
   localparam int RSP_USER_W = 2;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_SEL_LO = 3;

   // input register, accumulate stage, then the dequantiser stages
   localparam int PIPE_DEPTH = 7;
   localparam int DQ_FIRST   = 3;
   localparam int DQ_STAGES  = PIPE_DEPTH - DQ_FIRST + 1;

   typedef enum logic [2:0] {
      REG_MIN_X  = 3'd0,
      REG_MIN_Y  = 3'd1,
      REG_MIN_Z  = 3'd2,
      REG_SPAN_X = 3'd3,
      REG_SPAN_Y = 3'd4,
      REG_SPAN_Z = 3'd5
   } csr_reg_type;

   typedef enum logic {
      KIND_VERTEX = 1'b0,
      KIND_INDEX  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic              range_error;
      logic [IDX_W-1:0]  corner_idx;
   } side_type;

endpackage

// ===== rtl/qmsd_span_div.sv =====
// divider that splits a span into quotient and remainder by the quantisation maximum
module qmsd_span_div
   import qmsd_pkg::*;
#(
   parameter int QUANT_MAX = QUANT_MAX_DEF,
   localparam int QW = $clog2(QUANT_MAX + 1),
   localparam longint unsigned AMAX = ((64'd1 << SPAN_W) - 64'd1) / QUANT_MAX,
   localparam int AW = $clog2(AMAX + 1)
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SPAN_W-1:0] dividend,
   output logic              busy,
   output logic [AW-1:0]     quo,
   output logic [QW-1:0]     rem
);

   // long division in 16-bit digits, each digit found by
   // a reciprocal estimate, then one compare and subtract
   localparam int DIG_W  = 16;
   localparam int DIGITS = (SPAN_W + DIG_W - 1) / DIG_W;
   localparam int PAD_W  = DIGITS * DIG_W;
   localparam int XW     = QW + DIG_W;
   localparam longint unsigned RECIP = (64'd1 << 32) / QUANT_MAX;
   localparam int MW     = $clog2(RECIP + 1);
   localparam int EW     = XW + MW;
   localparam int CNT_W  = $clog2(2 * DIGITS + 1);
   localparam longint unsigned QUO_RST = SPAN_RST / QUANT_MAX;
   localparam longint unsigned REM_RST = SPAN_RST % QUANT_MAX;

   logic [PAD_W-1:0]  dvd_ff, dvd_in;
   logic [QW-1:0]     rem_ff, rem_in;
   logic [DIG_W-1:0]  est_ff, est_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [XW-1:0]     x;
   logic [EW-1:0]     prod;
   logic [XW-1:0]     part;
   logic [XW-1:0]     diff;
   logic              fits;

   always_comb begin
      x      = {rem_ff, dvd_ff[PAD_W-1 -: DIG_W]};
      prod   = EW'(x) * EW'(RECIP);
      part   = XW'(est_ff) * XW'(QUANT_MAX);
      diff   = x - part;
      fits   = diff >= XW'(QUANT_MAX);
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      est_in = est_ff;
      cnt_in = cnt_ff;
      if (start) begin
         dvd_in = PAD_W'(dividend);
         rem_in = '0;
         cnt_in = CNT_W'(2 * DIGITS);
      end else if (cnt_ff != '0) begin
         if (!cnt_ff[0]) begin
            // the estimate is the digit quotient or one short of it
            est_in = DIG_W'(prod >> 32);
         end else begin
            // quotient digits shift in as the dividend digits shift out
            rem_in = fits ? QW'(diff - XW'(QUANT_MAX)) : QW'(diff);
            dvd_in = {dvd_ff[PAD_W-DIG_W-1:0], est_ff + DIG_W'(fits)};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvd_ff <= PAD_W'(QUO_RST);
         rem_ff <= QW'(REM_RST);
         est_ff <= '0;
         cnt_ff <= '0;
      end else begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
         est_ff <= est_in;
         cnt_ff <= cnt_in;
      end
   end

   assign busy = cnt_ff != '0;
   assign quo  = dvd_ff[AW-1:0];
   assign rem  = rem_ff;

endmodule

// ===== rtl/qmsd_csr.sv =====
// configuration registers with apb access and per-axis span dividers
module qmsd_csr
   import qmsd_pkg::*;
#(
   parameter int QUANT_MAX = QUANT_MAX_DEF,
   localparam int QW = $clog2(QUANT_MAX + 1),
   localparam longint unsigned AMAX = ((64'd1 << SPAN_W) - 64'd1) / QUANT_MAX,
   localparam int AW = $clog2(AMAX + 1)
)(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]             csr_paddr,
   input  logic [CSR_DATA_W-1:0]             csr_pwdata,
   output logic [CSR_DATA_W-1:0]             csr_prdata,
   output logic                              csr_pready,
   output logic [AXES-1:0][MIN_W-1:0]        lo,
   output logic [AXES-1:0][AW-1:0]           span_quo,
   output logic [AXES-1:0][QW-1:0]           span_rem,
   output logic                              busy
);

   logic [AXES-1:0][MIN_W-1:0]  min_ff, min_in;
   logic [AXES-1:0][SPAN_W-1:0] span_ff, span_in;
   logic [AXES-1:0]             div_start;
   logic [AXES-1:0]             div_busy;
   logic                        wr;
   csr_reg_type                 sel;

   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign sel = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:CSR_SEL_LO]);

   always_comb begin
      min_in    = min_ff;
      span_in   = span_ff;
      div_start = '0;
      if (wr) begin
         case (sel)
            REG_MIN_X:  min_in[0] = csr_pwdata[MIN_W-1:0];
            REG_MIN_Y:  min_in[1] = csr_pwdata[MIN_W-1:0];
            REG_MIN_Z:  min_in[2] = csr_pwdata[MIN_W-1:0];
            REG_SPAN_X: begin
               span_in[0]   = csr_pwdata[SPAN_W-1:0];
               div_start[0] = 1'b1;
            end
            REG_SPAN_Y: begin
               span_in[1]   = csr_pwdata[SPAN_W-1:0];
               div_start[1] = 1'b1;
            end
            REG_SPAN_Z: begin
               span_in[2]   = csr_pwdata[SPAN_W-1:0];
               div_start[2] = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_MIN_X:  csr_prdata = CSR_DATA_W'(min_ff[0]);
         REG_MIN_Y:  csr_prdata = CSR_DATA_W'(min_ff[1]);
         REG_MIN_Z:  csr_prdata = CSR_DATA_W'(min_ff[2]);
         REG_SPAN_X: csr_prdata = CSR_DATA_W'(span_ff[0]);
         REG_SPAN_Y: csr_prdata = CSR_DATA_W'(span_ff[1]);
         REG_SPAN_Z: csr_prdata = CSR_DATA_W'(span_ff[2]);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= '0;
         span_ff <= {AXES{SPAN_W'(SPAN_RST)}};
      end else begin
         min_ff  <= min_in;
         span_ff <= span_in;
      end
   end

   for (genvar a = 0; a < AXES; a++) begin : g_div
      qmsd_span_div #(
         .QUANT_MAX (QUANT_MAX)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start[a]),
         .dividend (csr_pwdata[SPAN_W-1:0]),
         .busy     (div_busy[a]),
         .quo      (span_quo[a]),
         .rem      (span_rem[a])
      );
   end

   assign lo         = min_ff;
   assign busy       = |div_busy;
   assign csr_pready = 1'b1;

endmodule

// ===== rtl/qmsd_front.sv =====
// input register, zig-zag decode, accumulators, high-water mark and clamping
module qmsd_front
   import qmsd_pkg::*;
#(
   parameter int QUANT_MAX = QUANT_MAX_DEF,
   localparam int QW = $clog2(QUANT_MAX + 1)
)(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_in,
   input  logic                          load_mid,
   input  logic                          step,
   input  kind_type                      kind,
   input  logic                          start_of_mesh,
   input  logic [AXES-1:0][CODE_W-1:0]   codes,
   input  logic [IDX_W-1:0]              index_code,
   output logic [AXES-1:0][QW-1:0]       quant,
   output side_type                      side
);

   localparam logic [IDX_W-1:0] HW_TOP = '1;

   function automatic logic [ACC_W-1:0] zz_delta(input logic [CODE_W-1:0] code);
      logic signed [CODE_W-1:0] d;
      d = {1'b0, code[CODE_W-1:1]} ^ {CODE_W{code[0]}};
      return ACC_W'(d);
   endfunction

   // input register
   kind_type                     kind1_ff;
   logic                         start1_ff;
   logic [AXES-1:0][CODE_W-1:0]  code1_ff;
   logic [IDX_W-1:0]             index1_ff;

   // running state
   logic [AXES-1:0][ACC_W-1:0]   acc_ff, acc_in;
   logic [IDX_W-1:0]             hw_ff, hw_in;

   // accumulate stage
   logic [AXES-1:0][QW-1:0]      quant2_ff, quant2_in;
   side_type                     side2_ff, side2_in;

   logic [AXES-1:0][ACC_W-1:0]   base, sum;
   logic [AXES-1:0]              clip;
   logic [IDX_W-1:0]             hw_base, hw_next, idx;
   logic                         neg;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         base[a] = start1_ff ? '0 : acc_ff[a];
         sum[a]  = base[a] + zz_delta(code1_ff[a]);
         if (sum[a][ACC_W-1]) begin
            quant2_in[a] = '0;
            clip[a]      = 1'b1;
         end else if (sum[a] > ACC_W'(QUANT_MAX)) begin
            quant2_in[a] = QW'(QUANT_MAX);
            clip[a]      = 1'b1;
         end else begin
            quant2_in[a] = sum[a][QW-1:0];
            clip[a]      = 1'b0;
         end
      end

      hw_base = start1_ff ? '0 : hw_ff;
      neg     = index1_ff > hw_base;
      idx     = neg ? '0 : hw_base - index1_ff;
      // the mark saturates at all ones
      hw_next = (index1_ff == '0 && hw_base != HW_TOP) ? hw_base + 1'b1 : hw_base;

      side2_in.kind = kind1_ff;
      if (kind1_ff == KIND_INDEX) begin
         side2_in.range_error = neg;
         side2_in.corner_idx  = idx;
         acc_in               = base;
         hw_in                = hw_next;
      end else begin
         side2_in.range_error = |clip;
         side2_in.corner_idx  = '0;
         acc_in               = sum;
         hw_in                = hw_base;
      end
      if (!step) begin
         acc_in = acc_ff;
         hw_in  = hw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         hw_ff  <= '0;
      end else begin
         acc_ff <= acc_in;
         hw_ff  <= hw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         kind1_ff  <= kind;
         start1_ff <= start_of_mesh;
         code1_ff  <= codes;
         index1_ff <= index_code;
      end
      if (load_mid) begin
         quant2_ff <= quant2_in;
         side2_ff  <= side2_in;
      end
   end

   assign quant = quant2_ff;
   assign side  = side2_ff;

endmodule

// ===== rtl/qmsd_dequant.sv =====
// pipelined dequantiser for one axis: min + round(c * span / quant_max), saturated
module qmsd_dequant
   import qmsd_pkg::*;
#(
   parameter int QUANT_MAX  = QUANT_MAX_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int QW = $clog2(QUANT_MAX + 1),
   localparam longint unsigned AMAX = ((64'd1 << SPAN_W) - 64'd1) / QUANT_MAX,
   localparam int AW = $clog2(AMAX + 1)
)(
   input  logic                   clock,
   input  logic [DQ_STAGES-1:0]   adv,
   input  logic [QW-1:0]          quant,
   input  logic [AW-1:0]          span_quo,
   input  logic [QW-1:0]          span_rem,
   input  logic [MIN_W-1:0]       lo,
   output logic [COORD_BITS-1:0]  coord
);

   localparam int PW    = AW + QW;
   localparam int XW    = 2 * QW;
   // rounds up exactly when twice the remainder reaches quant_max
   localparam int HALF  = QUANT_MAX / 2;
   localparam longint unsigned RECIP = (64'd1 << 32) / QUANT_MAX;
   localparam int MW    = $clog2(RECIP + 1);
   localparam int EW    = XW + MW + 1;
   localparam int SUM_W = MIN_W + 1;

   logic [PW-1:0]          p3_ff, p4_ff, p5_ff;
   logic [XW-1:0]          x3_ff, x4_ff;
   logic [QW:0]            q4_ff, q5_ff;
   logic [SPAN_W-1:0]      off6_ff;
   logic [COORD_BITS-1:0]  coord7_ff;

   logic [PW-1:0]          p3_in;
   logic [XW-1:0]          x3_in;
   logic [EW-1:0]          est;
   logic [QW:0]            q4_in, q5_in;
   logic [XW-1:0]          qq, rr;
   logic [SPAN_W-1:0]      off6_in;
   logic signed [SUM_W-1:0] sum;
   logic [COORD_BITS-1:0]  coord7_in;

   // span = quo * quant_max + rem, so only the small part c * rem needs dividing
   assign p3_in = PW'(quant) * PW'(span_quo);
   assign x3_in = XW'(XW'(quant) * XW'(span_rem) + XW'(HALF));

   // reciprocal estimate, at most one short of the quotient
   assign est   = EW'(x3_ff) * EW'(RECIP);
   assign q4_in = (QW+1)'(est >> 32);

   assign qq    = XW'(XW'(q4_ff) * XW'(QUANT_MAX));
   assign rr    = x4_ff - qq;
   assign q5_in = q4_ff + (QW+1)'(rr >= XW'(QUANT_MAX));

   assign off6_in = SPAN_W'(p5_ff + PW'(q5_ff));

   assign sum = $signed({lo[MIN_W-1], lo}) + $signed({2'b00, off6_ff});

   if (COORD_BITS >= SUM_W) begin : g_wide
      assign coord7_in = COORD_BITS'(sum);
   end else begin : g_sat
      logic [SUM_W-COORD_BITS:0] top_bits;
      logic                      in_range;
      assign top_bits  = sum[SUM_W-1:COORD_BITS-1];
      assign in_range  = (&top_bits) | ~(|top_bits);
      assign coord7_in = in_range ? sum[COORD_BITS-1:0]
                                  : {sum[SUM_W-1], {(COORD_BITS-1){~sum[SUM_W-1]}}};
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         p3_ff <= p3_in;
         x3_ff <= x3_in;
      end
      if (adv[1]) begin
         p4_ff <= p3_ff;
         x4_ff <= x3_ff;
         q4_ff <= q4_in;
      end
      if (adv[2]) begin
         p5_ff <= p4_ff;
         q5_ff <= q5_in;
      end
      if (adv[3]) begin
         off6_ff <= off6_in;
      end
      if (adv[4]) begin
         coord7_ff <= coord7_in;
      end
   end

   assign coord = coord7_ff;

endmodule

// ===== rtl/quantized_mesh_stream_decoder.sv =====
// a word goes through the input register, accumulate and dequantiser stages to rsp
// one word per cycle unless stalled; each stage fills whenever the next one moves or is empty
// writing a span register starts a long divide of that span; req_tready is low meanwhile
// reset clears accumulators, high-water mark and the pipeline, and loads register defaults
// (min 0, span 65536) together with their precomputed quotients
module quantized_mesh_stream_decoder
   import qmsd_pkg::*;
#(
   parameter int QUANT_MAX  = QUANT_MAX_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int RSP_DATA_W = ((3 * COORD_BITS + IDX_W + 7) / 8) * 8
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // code_u, code_v, code_h, index_code
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // kind, start_of_mesh
   input  logic [REQ_USER_W-1:0]  req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // coord_x, coord_y, coord_z, corner index, zero fill
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // out_kind, range_error
   output logic [RSP_USER_W-1:0]  rsp_tuser,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int QW = $clog2(QUANT_MAX + 1);
   localparam longint unsigned AMAX = ((64'd1 << SPAN_W) - 64'd1) / QUANT_MAX;
   localparam int AW = $clog2(AMAX + 1);

   logic [PIPE_DEPTH:1]              v_ff, v_in;
   logic [PIPE_DEPTH+1:1]            en;
   side_type                         side_ff [PIPE_DEPTH:DQ_FIRST];
   side_type                         side_mid;
   logic [AXES-1:0][QW-1:0]          quant;
   logic [AXES-1:0][MIN_W-1:0]       lo;
   logic [AXES-1:0][AW-1:0]          span_quo;
   logic [AXES-1:0][QW-1:0]          span_rem;
   logic [AXES-1:0][COORD_BITS-1:0]  coord;
   logic [AXES-1:0][COORD_BITS-1:0]  coord_out;
   logic [AXES-1:0][CODE_W-1:0]      codes;
   logic                             div_busy;
   logic                             accept;

   // a stage may load when it is empty or its word moves on
   always_comb begin
      en[PIPE_DEPTH+1] = rsp_tready;
      for (int k = PIPE_DEPTH; k >= 1; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
   end

   assign req_tready = en[1] & ~div_busy;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      v_in = v_ff;
      if (en[1]) begin
         v_in[1] = accept;
      end
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
         if (en[k]) begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[DQ_FIRST]) begin
         side_ff[DQ_FIRST] <= side_mid;
      end
      for (int k = DQ_FIRST + 1; k <= PIPE_DEPTH; k++) begin
         if (en[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   qmsd_csr #(
      .QUANT_MAX (QUANT_MAX)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .lo          (lo),
      .span_quo    (span_quo),
      .span_rem    (span_rem),
      .busy        (div_busy)
   );

   assign codes[0] = req_tdata[CODE_W-1:0];
   assign codes[1] = req_tdata[2*CODE_W-1:CODE_W];
   assign codes[2] = req_tdata[3*CODE_W-1:2*CODE_W];

   qmsd_front #(
      .QUANT_MAX (QUANT_MAX)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .load_in       (en[1]),
      .load_mid      (en[2]),
      .step          (en[2] & v_ff[1]),
      .kind          (kind_type'(req_tuser[0])),
      .start_of_mesh (req_tuser[1]),
      .codes         (codes),
      .index_code    (req_tdata[REQ_DATA_W-1:3*CODE_W]),
      .quant         (quant),
      .side          (side_mid)
   );

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      qmsd_dequant #(
         .QUANT_MAX  (QUANT_MAX),
         .COORD_BITS (COORD_BITS)
      ) u_dequant (
         .clock    (clock),
         .adv      (en[PIPE_DEPTH:DQ_FIRST]),
         .quant    (quant[a]),
         .span_quo (span_quo[a]),
         .span_rem (span_rem[a]),
         .lo       (lo[a]),
         .coord    (coord[a])
      );
      // index words carry no position
      assign coord_out[a] = (side_ff[PIPE_DEPTH].kind == KIND_INDEX) ? '0 : coord[a];
   end

   assign rsp_tvalid = v_ff[PIPE_DEPTH];
   assign rsp_tdata  = RSP_DATA_W'({side_ff[PIPE_DEPTH].corner_idx,
                                    coord_out[2], coord_out[1], coord_out[0]});
   assign rsp_tuser  = {side_ff[PIPE_DEPTH].range_error, side_ff[PIPE_DEPTH].kind};

endmodule

// ===== bench/quantized_mesh_stream_decoder_tb.sv =====
// testbench of the quantized mesh stream decoder: directed and random words checked against a predictor
module quantized_mesh_stream_decoder_tb;
   import qmsd_pkg::*;

   localparam int COORD_W      = COORD_BITS_DEF;
   localparam int RSP_W        = ((3 * COORD_W + IDX_W + 7) / 8) * 8;
   localparam int CYCLE_CAP    = 300000;
   localparam int RANDOM_WORDS = 1100;
   localparam int SEGMENTS     = 6;
   localparam longint unsigned QMAX = QUANT_MAX_DEF;
   localparam longint COORD_TOP = (longint'(1) <<< (COORD_W - 1)) - 1;
   localparam longint COORD_BOT = -COORD_TOP - 1;
   localparam logic [MIN_W-1:0] MIN_TOP = {1'b0, {(MIN_W-1){1'b1}}};
   localparam logic [MIN_W-1:0] MIN_BOT = {1'b1, {(MIN_W-1){1'b0}}};

   typedef struct packed {
      kind_type           kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [IDX_W-1:0]   index;
      logic               err;
   } mesh_result_type;

   class mesh_scoreboard_type;
      logic signed [MIN_W-1:0] lo [AXES];
      logic [SPAN_W-1:0]       span [AXES];
      logic [ACC_W-1:0]        acc [AXES];
      logic [IDX_W-1:0]        high_water;
      mesh_result_type         expected_q [$];
      int                      fails;

      function new();
         for (int a = 0; a < AXES; a++) begin
            lo[a]   = '0;
            span[a] = SPAN_W'(SPAN_RST);
            acc[a]  = '0;
         end
         high_water = '0;
         fails      = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void set_reg(csr_reg_type r, logic [CSR_DATA_W-1:0] v);
         if (r <= REG_MIN_Z) lo[int'(r)] = v[MIN_W-1:0];
         else span[int'(r) - int'(REG_SPAN_X)] = v[SPAN_W-1:0];
      endfunction

      function logic [COORD_W-1:0] dequantise(logic [ACC_W-1:0] a, int axis, inout logic bad);
         longint unsigned c, prod, q, r;
         longint sum;
         if (a[ACC_W-1]) begin
            c   = 0;
            bad = 1'b1;
         end else if (a > ACC_W'(QUANT_MAX_DEF)) begin
            c   = QMAX;
            bad = 1'b1;
         end else begin
            c = a;
         end
         prod = c * span[axis];
         q    = prod / QMAX;
         r    = prod % QMAX;
         if (2 * r >= QMAX) q++;
         sum = longint'(lo[axis]) + longint'(q);
         if (sum > COORD_TOP) sum = COORD_TOP;
         else if (sum < COORD_BOT) sum = COORD_BOT;
         return sum[COORD_W-1:0];
      endfunction

      function void note_word(kind_type k, logic start, logic [3*CODE_W-1:0] codes,
                              logic [IDX_W-1:0] ic);
         mesh_result_type e;
         logic [CODE_W-1:0] cz;
         logic bad;
         e   = '0;
         bad = 1'b0;
         e.kind = k;
         if (start) begin
            for (int a = 0; a < AXES; a++) acc[a] = '0;
            high_water = '0;
         end
         if (k == KIND_VERTEX) begin
            for (int a = 0; a < AXES; a++) begin
               cz = codes[a*CODE_W +: CODE_W];
               acc[a] += ACC_W'(cz >> 1) ^ (ACC_W'(0) - ACC_W'(cz[0]));
            end
            e.x = dequantise(acc[0], 0, bad);
            e.y = dequantise(acc[1], 1, bad);
            e.z = dequantise(acc[2], 2, bad);
         end else begin
            if (ic > high_water) bad = 1'b1;
            else e.index = high_water - ic;
            // the mark stops at all ones rather than wrapping
            if (ic == '0 && high_water != '1) high_water++;
         end
         e.err = bad;
         expected_q.insert(expected_q.size(), e);
      endfunction

      function string show(mesh_result_type r);
         return $sformatf("kind %0d x %h y %h z %h index %h err %b",
                          r.kind, r.x, r.y, r.z, r.index, r.err);
      endfunction

      function void note_fail(string what);
         fails++;
         if (fails <= 10) $display("mismatch: %s", what);
      endfunction

      function void check_word(logic [RSP_W-1:0] d, logic [RSP_USER_W-1:0] u);
         mesh_result_type e, g;
         g.kind  = kind_type'(u[0]);
         g.err   = u[1];
         g.x     = d[0 +: COORD_W];
         g.y     = d[COORD_W +: COORD_W];
         g.z     = d[2*COORD_W +: COORD_W];
         g.index = d[3*COORD_W +: IDX_W];
         if (expected_q.size() == 0) begin
            note_fail({"word with nothing pending, got ", show(g)});
         end else begin
            e = expected_q.pop_front();
            if (g.kind !== e.kind || g.x !== e.x || g.y !== e.y || g.z !== e.z
                || g.index !== e.index || g.err !== e.err)
               note_fail({"expected ", show(e), " got ", show(g)});
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // code_u, code_v, code_h, index_code
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   // kind, start_of_mesh
   logic [REQ_USER_W-1:0]   req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // coord_x, coord_y, coord_z, corner index, zero fill
   logic [RSP_W-1:0]        rsp_tdata;
   // out_kind, range_error
   logic [RSP_USER_W-1:0]   rsp_tuser;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   mesh_scoreboard_type sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycles = 0;
   int mesh_verts = 0;
   int mesh_indices = 0;

   quantized_mesh_stream_decoder u_top (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_CAP) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser);
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [CODE_W-1:0] zigzag(int d);
      return CODE_W'((d <<< 1) ^ (d >>> 31));
   endfunction

   task automatic send_word(input kind_type k, input logic s, input logic [3*CODE_W-1:0] codes,
                            input logic [IDX_W-1:0] ic);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ic, codes};
      req_tuser  <= {s, k};
      do @(posedge clock); while (!req_tready);
      sb.note_word(k, s, codes, ic);
   endtask

   task automatic vertex_word(input logic s, input logic [CODE_W-1:0] u, v, h);
      send_word(KIND_VERTEX, s, {h, v, u}, $urandom);
   endtask

   task automatic index_word(input logic s, input logic [IDX_W-1:0] c);
      send_word(KIND_INDEX, s, {CODE_W'($urandom), $urandom}, c);
   endtask

   // hold the sender off until every pending word has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic load_setting(input int seg);
      logic [MIN_W-1:0]      lo;
      logic [SPAN_W-1:0]     sp;
      logic [CSR_DATA_W-1:0] val [2*AXES];
      csr_reg_type           r;
      for (int a = 0; a < AXES; a++) begin
         case (seg)
            0: begin
               lo = MIN_W'(signed'($urandom));
               sp = SPAN_W'($urandom);
            end
            1: begin
               // top saturates, bottom sits exactly on the lower bound
               lo = (a == 0) ? MIN_TOP : ((a == 1) ? MIN_BOT : '0);
               sp = (a == 1) ? '0 : '1;
            end
            2: begin
               lo = MIN_BOT;
               sp = '1;
            end
            3: begin
               lo = MIN_W'({$urandom, $urandom});
               sp = SPAN_W'({$urandom, $urandom});
            end
            4: begin
               lo = ~MIN_W'($urandom_range(65535));
               sp = (a == 2) ? SPAN_W'(QUANT_MAX_DEF) : SPAN_W'(1);
            end
            default: begin
               lo = '0;
               sp = SPAN_W'(SPAN_RST);
            end
         endcase
         val[a]        = {{(CSR_DATA_W-MIN_W){lo[MIN_W-1]}}, lo};
         val[AXES + a] = {{(CSR_DATA_W-SPAN_W){1'b0}}, sp};
      end
      for (int i = 0; i < 2*AXES; i++) begin
         r = csr_reg_type'(i);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {r, {CSR_SEL_LO{1'b0}}};
         csr_pwdata  <= val[i];
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         sb.set_reg(r, val[i]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // mostly whole meshes: a run of vertices with bounded deltas, then corner codes
   task automatic random_word();
      kind_type             k;
      logic                 s;
      logic [3*CODE_W-1:0]  codes;
      logic [IDX_W-1:0]     ic;
      logic [IDX_W-1:0]     hw;
      int                   cur, target, d, pick;
      codes = {CODE_W'($urandom), $urandom};
      ic    = $urandom;
      s     = 1'b0;
      k     = KIND_VERTEX;
      if ($urandom_range(99) < 8) begin
         k = kind_type'($urandom_range(1));
         s = ($urandom_range(3) == 0);
      end else begin
         if (mesh_verts == 0 && mesh_indices == 0) begin
            mesh_verts   = $urandom_range(20, 1);
            mesh_indices = $urandom_range(30, 1);
            s = 1'b1;
         end
         if (mesh_verts > 0) begin
            mesh_verts--;
            for (int a = 0; a < AXES; a++) begin
               cur  = s ? 0 : int'(signed'(sb.acc[a]));
               pick = $urandom_range(9);
               if (pick == 0) begin
                  target = $urandom_range(QUANT_MAX_DEF);
               end else if (pick == 1) begin
                  target = cur + int'($urandom_range(65535)) - 32768;
               end else begin
                  target = cur + int'($urandom_range(4000)) - 2000;
                  if (target < 0) target = 0;
                  if (target > QUANT_MAX_DEF) target = QUANT_MAX_DEF;
               end
               d = target - cur;
               if (d > 32767) d = 32767;
               if (d < -32768) d = -32768;
               codes[a*CODE_W +: CODE_W] = zigzag(d);
            end
         end else begin
            k = KIND_INDEX;
            mesh_indices--;
            hw = s ? '0 : sb.high_water;
            pick = $urandom_range(19);
            if (pick == 0) ic = hw + 1 + $urandom_range(3);
            else if (pick < 8) ic = '0;
            else ic = $urandom_range(hw);
         end
      end
      send_word(k, s, codes, ic);
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 17;
      recv_idle_pct = 85;

      vertex_word(1'b1, 16'h0000, 16'h0000, 16'h0000);
      // full positive swing, full negative swing, one below zero
      vertex_word(1'b0, 16'hFFFE, 16'hFFFF, 16'h0001);
      vertex_word(1'b0, 16'h0002, 16'hFFFE, 16'h0002);
      vertex_word(1'b1, 16'hFFFE, 16'hFFFE, 16'hFFFE);
      index_word(1'b1, 32'd0);
      index_word(1'b0, 32'd0);
      index_word(1'b0, 32'd0);
      index_word(1'b0, 32'd3);
      index_word(1'b0, 32'd4);
      index_word(1'b0, 32'hFFFF_FFFF);
      index_word(1'b0, 32'd1);
      vertex_word(1'b0, 16'h0000, 16'h0000, 16'h0000);
      index_word(1'b0, 32'd0);
      vertex_word(1'b1, 16'h0001, 16'h0000, 16'h8000);
      index_word(1'b1, 32'd1);
      index_word(1'b0, 32'd0);
      // remainders just under and at half a step
      vertex_word(1'b1, 16'h4000, 16'h3FFE, 16'h8000);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         if (seg == 2) begin
            send_idle_pct = 85;
            recv_idle_pct = 17;
         end else if (seg == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         load_setting(seg);
         for (int n = 0; n < RANDOM_WORDS / SEGMENTS; n++) begin
            if (n == 90) drain();
            random_word();
         end
      end

      drain();
      repeat (4 * PIPE_DEPTH) @(posedge clock);
      if (sb.fails == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/qmsd_pkg.sv
rtl/qmsd_span_div.sv
rtl/qmsd_csr.sv
rtl/qmsd_front.sv
rtl/qmsd_dequant.sv
rtl/quantized_mesh_stream_decoder.sv
bench/quantized_mesh_stream_decoder_tb.sv
